// File: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define RFB_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define RFB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/rfb_pkg.sv
// Package: constants, coefficient table and coefficient function of the radix-5 butterfly.
package rfb_pkg;

    localparam int RFB_POINTS         = 5;
    localparam int RFB_SAMPLE_WIDTH   = 24;
    localparam int RFB_COEF_FRAC_BITS = 16;
    localparam int RFB_OUT_EXTRA      = 3;
    localparam int RFB_NCOEF          = 5;

    typedef enum logic [2:0] {
        RFB_CC1,
        RFB_CC2,
        RFB_S,
        RFB_SS1,
        RFB_SS2
    } rfb_coef_t;

    // |c| * 2^32, rounded
    localparam longint unsigned RFB_K32 [RFB_NCOEF] = '{
        64'd5368709120, 64'd2400959709, 64'd4084756634, 64'd6609275070, 64'd1560238198
    };

    // coefficient scaled by 2^frac_bits, rounded ties up, sign applied
    function automatic longint rfb_coef(input rfb_coef_t idx, input int frac_bits);
        int              sh;
        longint unsigned v;
        sh = 32 - frac_bits;
        v  = (RFB_K32[int'(idx)] + (64'd1 << (sh - 1))) >> sh;
        if (idx == RFB_CC1)
            return -longint'(v);
        return longint'(v);
    endfunction

endpackage

// File: rtl/rfb_in_if.sv
// Input channel: five complex samples and the direction bit.
interface rfb_in_if
    import rfb_pkg::*;
#(
    parameter int SAMPLE_WIDTH = RFB_SAMPLE_WIDTH
);
    logic                           valid;
    logic                           ready;
    logic                           action;
    logic signed [SAMPLE_WIDTH-1:0] in0_re;
    logic signed [SAMPLE_WIDTH-1:0] in0_im;
    logic signed [SAMPLE_WIDTH-1:0] in1_re;
    logic signed [SAMPLE_WIDTH-1:0] in1_im;
    logic signed [SAMPLE_WIDTH-1:0] in2_re;
    logic signed [SAMPLE_WIDTH-1:0] in2_im;
    logic signed [SAMPLE_WIDTH-1:0] in3_re;
    logic signed [SAMPLE_WIDTH-1:0] in3_im;
    logic signed [SAMPLE_WIDTH-1:0] in4_re;
    logic signed [SAMPLE_WIDTH-1:0] in4_im;

    modport source (
        output valid, action, in0_re, in0_im, in1_re, in1_im, in2_re, in2_im,
               in3_re, in3_im, in4_re, in4_im,
        input  ready
    );

    modport sink (
        input  valid, action, in0_re, in0_im, in1_re, in1_im, in2_re, in2_im,
               in3_re, in3_im, in4_re, in4_im,
        output ready
    );
endinterface

// File: rtl/rfb_out_if.sv
// Output channel: five complex DFT results.
interface rfb_out_if
    import rfb_pkg::*;
#(
    parameter int SAMPLE_WIDTH = RFB_SAMPLE_WIDTH
);
    localparam int OW = SAMPLE_WIDTH + RFB_OUT_EXTRA;

    logic                 valid;
    logic                 ready;
    logic signed [OW-1:0] out0_re;
    logic signed [OW-1:0] out0_im;
    logic signed [OW-1:0] out1_re;
    logic signed [OW-1:0] out1_im;
    logic signed [OW-1:0] out2_re;
    logic signed [OW-1:0] out2_im;
    logic signed [OW-1:0] out3_re;
    logic signed [OW-1:0] out3_im;
    logic signed [OW-1:0] out4_re;
    logic signed [OW-1:0] out4_im;

    modport source (
        output valid, out0_re, out0_im, out1_re, out1_im, out2_re, out2_im,
               out3_re, out3_im, out4_re, out4_im,
        input  ready
    );

    modport sink (
        input  valid, out0_re, out0_im, out1_re, out1_im, out2_re, out2_im,
               out3_re, out3_im, out4_re, out4_im,
        output ready
    );
endinterface

// File: rtl/rfb_round_mul.sv
// Constant multiplier with round to nearest, ties toward plus infinity.
module rfb_round_mul
    import rfb_pkg::*;
#(
    parameter int IW = RFB_SAMPLE_WIDTH + 2,
    parameter int CW = RFB_COEF_FRAC_BITS + 2,
    parameter int F  = RFB_COEF_FRAC_BITS,
    parameter int PW = RFB_SAMPLE_WIDTH + 4,
    parameter logic signed [CW-1:0] COEF = '0
) (
    input  logic signed [IW-1:0] a,
    output logic signed [PW-1:0] q
);
    localparam int PRW = IW + CW;
    localparam logic signed [PRW:0] HALF = (PRW + 1)'(1) << (F - 1);

    logic signed [PRW-1:0] p;
    logic signed [PRW:0]   pr;
    logic signed [PRW:0]   sh;

    assign p  = PRW'(a) * PRW'(COEF);
    assign pr = (PRW + 1)'(p) + HALF;
    assign sh = pr >>> F;
    assign q  = sh[PW-1:0];
endmodule

// File: rtl/rfb_front_lane.sv
// Pre-adds and the five constant products for one lane (real or imaginary).
module rfb_front_lane
    import rfb_pkg::*;
#(
    parameter int W = RFB_SAMPLE_WIDTH,
    parameter int F = RFB_COEF_FRAC_BITS
) (
    input  logic signed [W-1:0]   x [RFB_POINTS],
    input  logic                  inverse,
    output logic signed [W+2:0]   sum0,
    output logic signed [W+3:0]   m_cc1,
    output logic signed [W+3:0]   m_cc2,
    output logic signed [W+3:0]   m_s,
    output logic signed [W+3:0]   m_ss1,
    output logic signed [W+3:0]   m_ss2
);
    localparam int IW = W + 2;
    localparam int CW = F + 2;
    localparam int PW = W + 4;

    localparam logic signed [CW-1:0] C_CC1 = CW'(rfb_coef(RFB_CC1, F));
    localparam logic signed [CW-1:0] C_CC2 = CW'(rfb_coef(RFB_CC2, F));
    localparam logic signed [CW-1:0] C_S   = CW'(rfb_coef(RFB_S, F));
    localparam logic signed [CW-1:0] C_SS1 = CW'(rfb_coef(RFB_SS1, F));
    localparam logic signed [CW-1:0] C_SS2 = CW'(rfb_coef(RFB_SS2, F));

    logic signed [W:0]    a14s;
    logic signed [W:0]    a23s;
    logic signed [W:0]    a23d;
    logic signed [W:0]    a14d;
    logic signed [IW-1:0] u0;
    logic signed [IW-1:0] d1;
    logic signed [IW-1:0] d2;

    always_comb
    begin
        a14s = (W + 1)'(x[1]) + (W + 1)'(x[4]);
        a23s = (W + 1)'(x[2]) + (W + 1)'(x[3]);
        a23d = (W + 1)'(x[2]) - (W + 1)'(x[3]);
        a14d = (W + 1)'(x[1]) - (W + 1)'(x[4]);
        u0   = IW'(a14s) + IW'(a23s);
        d1   = IW'(a14s) - IW'(a23s);
        // sine difference is formed in the order of the direction before rounding
        if (inverse)
            d2 = IW'(a23d) - IW'(a14d);
        else
            d2 = IW'(a14d) - IW'(a23d);
        sum0 = (W + 3)'(x[0]) + (W + 3)'(u0);
    end

    rfb_round_mul #(.IW(IW), .CW(CW), .F(F), .PW(PW), .COEF(C_CC1)) u_mul_cc1
    (
        .a(u0),
        .q(m_cc1)
    );

    rfb_round_mul #(.IW(IW), .CW(CW), .F(F), .PW(PW), .COEF(C_CC2)) u_mul_cc2
    (
        .a(d1),
        .q(m_cc2)
    );

    rfb_round_mul #(.IW(IW), .CW(CW), .F(F), .PW(PW), .COEF(C_S)) u_mul_s
    (
        .a(d2),
        .q(m_s)
    );

    rfb_round_mul #(.IW(IW), .CW(CW), .F(F), .PW(PW), .COEF(C_SS1)) u_mul_ss1
    (
        .a(IW'(a23d)),
        .q(m_ss1)
    );

    rfb_round_mul #(.IW(IW), .CW(CW), .F(F), .PW(PW), .COEF(C_SS2)) u_mul_ss2
    (
        .a(IW'(a14d)),
        .q(m_ss2)
    );
endmodule

// File: rtl/rfb_back.sv
// Post-adds across both lanes and output saturation.
module rfb_back
    import rfb_pkg::*;
#(
    parameter int W = RFB_SAMPLE_WIDTH
) (
    input  logic                            inverse,
    input  logic signed [W+2:0]             sum_re,
    input  logic signed [W+2:0]             sum_im,
    input  logic signed [W+3:0]             cc1_re,
    input  logic signed [W+3:0]             cc1_im,
    input  logic signed [W+3:0]             cc2_re,
    input  logic signed [W+3:0]             cc2_im,
    input  logic signed [W+3:0]             s_re,
    input  logic signed [W+3:0]             s_im,
    input  logic signed [W+3:0]             ss1_re,
    input  logic signed [W+3:0]             ss1_im,
    input  logic signed [W+3:0]             ss2_re,
    input  logic signed [W+3:0]             ss2_im,
    output logic signed [W+RFB_OUT_EXTRA-1:0] yr [RFB_POINTS],
    output logic signed [W+RFB_OUT_EXTRA-1:0] yi [RFB_POINTS]
);
    localparam int OW = W + RFB_OUT_EXTRA;
    localparam int AW = W + 6;
    localparam logic signed [AW-1:0] OMAX = AW'((longint'(1) << (OW - 1)) - 1);
    localparam logic signed [AW-1:0] OMIN = AW'(-(longint'(1) << (OW - 1)));

    function automatic logic signed [OW-1:0] sat(input logic signed [AW-1:0] v);
        if (v > OMAX)
            return OMAX[OW-1:0];
        if (v < OMIN)
            return OMIN[OW-1:0];
        return v[OW-1:0];
    endfunction

    logic signed [AW-1:0] u_re;
    logic signed [AW-1:0] u_im;
    logic signed [AW-1:0] r2_re;
    logic signed [AW-1:0] r2_im;
    logic signed [AW-1:0] r4_re;
    logic signed [AW-1:0] r4_im;
    logic signed [AW-1:0] t6;
    logic signed [AW-1:0] t7;
    logic signed [AW-1:0] t8;
    logic signed [AW-1:0] t9;

    always_comb
    begin
        u_re  = AW'(sum_re) + AW'(cc1_re);
        u_im  = AW'(sum_im) + AW'(cc1_im);
        r2_re = u_re + AW'(cc2_re);
        r2_im = u_im + AW'(cc2_im);
        r4_re = u_re - AW'(cc2_re);
        r4_im = u_im - AW'(cc2_im);
        if (inverse)
        begin
            t6 = AW'(s_re) - AW'(ss1_re);
            t7 = AW'(s_im) - AW'(ss1_im);
            t8 = AW'(s_re) + AW'(ss2_re);
            t9 = AW'(s_im) + AW'(ss2_im);
        end
        else
        begin
            t6 = AW'(s_re) + AW'(ss1_re);
            t7 = AW'(s_im) + AW'(ss1_im);
            t8 = AW'(s_re) - AW'(ss2_re);
            t9 = AW'(s_im) - AW'(ss2_im);
        end
        yr[0] = sat(AW'(sum_re));
        yi[0] = sat(AW'(sum_im));
        yr[1] = sat(r2_re - t7);
        yi[1] = sat(r2_im + t6);
        yr[2] = sat(r4_re - t9);
        yi[2] = sat(r4_im + t8);
        yr[3] = sat(r4_re + t9);
        yi[3] = sat(r4_im - t8);
        yr[4] = sat(r2_re + t7);
        yi[4] = sat(r2_im - t6);
    end
endmodule

// File: rtl/radix5_fft_butterfly_unit.sv
// Top level: radix-5 Winograd butterfly, three-stage pipeline with per-stage flow control.
//
//   channel   modport   transfer carries
//   in_ch     sink      action, in0_re .. in4_im   (five complex samples)
//   out_ch    source    out0_re .. out4_im         (five complex results, saturated)
//
// One butterfly per clock while out_ch is not stalled; registers: input, product, output.
// The product stage holds the ten rounded constant multiplies, one per coefficient and lane.
// rst_n clears the stage valid bits only; payload registers are not reset.
// Each stage advances when it is empty or the stage after it moves, so bubbles are
// squeezed out while out_ch is stalled and in_ch.ready drops only when all stages are full.
module radix5_fft_butterfly_unit
    import rfb_pkg::*;
#(
    parameter int SAMPLE_WIDTH   = RFB_SAMPLE_WIDTH,
    parameter int COEF_FRAC_BITS = RFB_COEF_FRAC_BITS
) (
    input  logic       clk,
    input  logic       rst_n,
    rfb_in_if.sink     in_ch,
    rfb_out_if.source  out_ch
);
    localparam int W  = SAMPLE_WIDTH;
    localparam int OW = W + RFB_OUT_EXTRA;

    logic en_i;
    logic en_p;
    logic en_o;

    logic vi_reg, vi_next;
    logic vp_reg, vp_next;
    logic vo_reg, vo_next;

    logic                 inv_i_reg, inv_next;
    logic signed [W-1:0]  xr_reg [RFB_POINTS];
    logic signed [W-1:0]  xi_reg [RFB_POINTS];
    logic signed [W-1:0]  xr_next [RFB_POINTS];
    logic signed [W-1:0]  xi_next [RFB_POINTS];

    logic                 inv_p_reg;
    logic signed [W+2:0]  sum_re_reg, sum_re_next;
    logic signed [W+2:0]  sum_im_reg, sum_im_next;
    logic signed [W+3:0]  cc1_re_reg, cc1_re_next;
    logic signed [W+3:0]  cc1_im_reg, cc1_im_next;
    logic signed [W+3:0]  cc2_re_reg, cc2_re_next;
    logic signed [W+3:0]  cc2_im_reg, cc2_im_next;
    logic signed [W+3:0]  s_re_reg, s_re_next;
    logic signed [W+3:0]  s_im_reg, s_im_next;
    logic signed [W+3:0]  ss1_re_reg, ss1_re_next;
    logic signed [W+3:0]  ss1_im_reg, ss1_im_next;
    logic signed [W+3:0]  ss2_re_reg, ss2_re_next;
    logic signed [W+3:0]  ss2_im_reg, ss2_im_next;

    logic signed [OW-1:0] yr_reg [RFB_POINTS];
    logic signed [OW-1:0] yi_reg [RFB_POINTS];
    logic signed [OW-1:0] yr_next [RFB_POINTS];
    logic signed [OW-1:0] yi_next [RFB_POINTS];

    always_comb
    begin
        en_o    = !vo_reg || out_ch.ready;
        en_p    = !vp_reg || en_o;
        en_i    = !vi_reg || en_p;
        vi_next = en_i ? in_ch.valid : vi_reg;
        vp_next = en_p ? vi_reg : vp_reg;
        vo_next = en_o ? vp_reg : vo_reg;
    end

    assign in_ch.ready = en_i;

    always_comb
    begin
        inv_next   = in_ch.action;
        xr_next[0] = in_ch.in0_re;
        xi_next[0] = in_ch.in0_im;
        xr_next[1] = in_ch.in1_re;
        xi_next[1] = in_ch.in1_im;
        xr_next[2] = in_ch.in2_re;
        xi_next[2] = in_ch.in2_im;
        xr_next[3] = in_ch.in3_re;
        xi_next[3] = in_ch.in3_im;
        xr_next[4] = in_ch.in4_re;
        xi_next[4] = in_ch.in4_im;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vi_reg <= 1'b0;
            vp_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            vi_reg <= vi_next;
            vp_reg <= vp_next;
            vo_reg <= vo_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_i && in_ch.valid)
        begin
            inv_i_reg <= inv_next;
            xr_reg    <= xr_next;
            xi_reg    <= xi_next;
        end
    end

    rfb_front_lane #(.W(W), .F(COEF_FRAC_BITS)) u_front_re
    (
        .x       (xr_reg),
        .inverse (inv_i_reg),
        .sum0    (sum_re_next),
        .m_cc1   (cc1_re_next),
        .m_cc2   (cc2_re_next),
        .m_s     (s_re_next),
        .m_ss1   (ss1_re_next),
        .m_ss2   (ss2_re_next)
    );

    rfb_front_lane #(.W(W), .F(COEF_FRAC_BITS)) u_front_im
    (
        .x       (xi_reg),
        .inverse (inv_i_reg),
        .sum0    (sum_im_next),
        .m_cc1   (cc1_im_next),
        .m_cc2   (cc2_im_next),
        .m_s     (s_im_next),
        .m_ss1   (ss1_im_next),
        .m_ss2   (ss2_im_next)
    );

    always_ff @(posedge clk)
    begin
        if (en_p && vi_reg)
        begin
            inv_p_reg  <= inv_i_reg;
            sum_re_reg <= sum_re_next;
            sum_im_reg <= sum_im_next;
            cc1_re_reg <= cc1_re_next;
            cc1_im_reg <= cc1_im_next;
            cc2_re_reg <= cc2_re_next;
            cc2_im_reg <= cc2_im_next;
            s_re_reg   <= s_re_next;
            s_im_reg   <= s_im_next;
            ss1_re_reg <= ss1_re_next;
            ss1_im_reg <= ss1_im_next;
            ss2_re_reg <= ss2_re_next;
            ss2_im_reg <= ss2_im_next;
        end
    end

    rfb_back #(.W(W)) u_back
    (
        .inverse (inv_p_reg),
        .sum_re  (sum_re_reg),
        .sum_im  (sum_im_reg),
        .cc1_re  (cc1_re_reg),
        .cc1_im  (cc1_im_reg),
        .cc2_re  (cc2_re_reg),
        .cc2_im  (cc2_im_reg),
        .s_re    (s_re_reg),
        .s_im    (s_im_reg),
        .ss1_re  (ss1_re_reg),
        .ss1_im  (ss1_im_reg),
        .ss2_re  (ss2_re_reg),
        .ss2_im  (ss2_im_reg),
        .yr      (yr_next),
        .yi      (yi_next)
    );

    always_ff @(posedge clk)
    begin
        if (en_o && vp_reg)
        begin
            yr_reg <= yr_next;
            yi_reg <= yi_next;
        end
    end

    assign out_ch.valid   = vo_reg;
    assign out_ch.out0_re = yr_reg[0];
    assign out_ch.out0_im = yi_reg[0];
    assign out_ch.out1_re = yr_reg[1];
    assign out_ch.out1_im = yi_reg[1];
    assign out_ch.out2_re = yr_reg[2];
    assign out_ch.out2_im = yi_reg[2];
    assign out_ch.out3_re = yr_reg[3];
    assign out_ch.out3_im = yi_reg[3];
    assign out_ch.out4_re = yr_reg[4];
    assign out_ch.out4_im = yi_reg[4];
endmodule

// File: rtl/rfb_checker.sv
// Port-level checker for the radix-5 butterfly and its bind to the top level.
`include "assert_macros.svh"

module rfb_checker
    import rfb_pkg::*;
#(
    parameter int SAMPLE_WIDTH = RFB_SAMPLE_WIDTH
) (
    input logic                                      clk,
    input logic                                      rst_n,
    input logic                                      in_valid,
    input logic                                      in_ready,
    input logic                                      out_valid,
    input logic                                      out_ready,
    input logic signed [SAMPLE_WIDTH+RFB_OUT_EXTRA-1:0] out0_re,
    input logic signed [SAMPLE_WIDTH+RFB_OUT_EXTRA-1:0] out4_im
);
    `RFB_ASSERT_NEXT(a_out_valid_hold, out_valid && !out_ready, out_valid, "out valid dropped while stalled")
    `RFB_ASSERT_NEXT(a_out_data_hold, out_valid && !out_ready, $stable(out0_re) && $stable(out4_im), "out data changed while stalled")
    `RFB_ASSERT_SAME(a_ready_when_empty, !out_valid, in_ready, "input not ready with empty output stage")
    `RFB_ASSERT_NEXT(a_latency, (in_valid && in_ready) ##1 out_ready ##1 out_ready, out_valid, "result missing three cycles after transfer")
endmodule

bind radix5_fft_butterfly_unit rfb_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_rfb_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out0_re   (out_ch.out0_re),
    .out4_im   (out_ch.out4_im)
);
